FILE: design/ssp_pkg.sv
// ----------------------------------------------------------------------------
// sprite screen projection package
// shared widths, constants, register indexes and the front-to-back item type
// ----------------------------------------------------------------------------
package ssp_pkg;

  // fixed point and screen geometry
  localparam int FRAC_BITS     = 16;
  localparam int VIEW_COLS     = 1280;
  localparam int SCREEN_HEIGHT = 720;

  // field widths
  localparam int POS_W  = 28;
  localparam int OFS_W  = POS_W + 1;
  localparam int DIR_W  = 19;
  localparam int INV_W  = 25;
  localparam int DIST_W = 29;
  localparam int CS_W   = 32;
  localparam int SCR_W  = 16;

  // camera transform datapath
  localparam int PROD_W = DIR_W + OFS_W;
  localparam int LIN_W  = PROD_W + 1 - FRAC_BITS;
  localparam int MUL_W  = LIN_W + INV_W;
  localparam int SHR_W  = MUL_W - FRAC_BITS;

  // square root datapath
  localparam int RAD_W    = 2 * POS_W + 1;
  localparam int SQ_STEPS = (RAD_W + 1) / 2;
  localparam int RAD_PAD  = 2 * SQ_STEPS;
  localparam int SREM_W   = SQ_STEPS + 2;

  // divider datapath
  localparam int SUM_W     = CS_W + 1;
  localparam int NUM_W     = SUM_W + $clog2(VIEW_COLS + 1);
  localparam int DEN_W     = CS_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam logic [NUM_W-1:0] HGT_NUM = NUM_W'(SCREEN_HEIGHT) << FRAC_BITS;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // stream and configuration port widths
  localparam int IN_TDATA_W  = ((2 * POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OFS_W + DIST_W + 2 * CS_W + 1 + 3 * SCR_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = POS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FACE_X  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FACE_Y  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_INV_DET = CFG_IDX_W'(6);

  // register reset values
  localparam logic [DIR_W-1:0] FACE_X_RESET  = DIR_W'(1) << FRAC_BITS;
  localparam logic [DIR_W-1:0] PLANE_Y_RESET = DIR_W'(43254);
  localparam logic [INV_W-1:0] INV_RESET     = INV_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic        [POS_W-1:0] cam_x;
    logic        [POS_W-1:0] cam_y;
    logic signed [DIR_W-1:0] face_x;
    logic signed [DIR_W-1:0] face_y;
    logic signed [DIR_W-1:0] plane_x;
    logic signed [DIR_W-1:0] plane_y;
    logic signed [INV_W-1:0] inv_det;
  } cam_cfg_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic        [RAD_W-1:0] rad;
    logic signed [CS_W-1:0]  tx;
    logic signed [CS_W-1:0]  td;
    logic                    vis;
  } front_item_t;

endpackage

FILE: design/ssp_front.sv
// ----------------------------------------------------------------------------
// sprite projection front
// offsets, squares and the camera transform in five stages; classifies depth
// ----------------------------------------------------------------------------
module ssp_front import ssp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cam_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [POS_W-1:0] in_x,
  input  logic [POS_W-1:0] in_y,
  output logic             out_valid,
  output front_item_t      out_item,
  input  logic             queue_full
);

  localparam int FS = 5;

  logic                      adv;
  logic [FS-1:0]             vld;

  logic signed [OFS_W-1:0]   ox1, oy1, ox2, oy2, ox3, oy3, ox4, oy4;
  logic        [POS_W-1:0]   ax, ay;
  logic signed [PROD_W-1:0]  p_fyox, p_fxoy, p_pxoy, p_pyox;
  logic        [2*POS_W-1:0] sqx, sqy;
  logic signed [PROD_W:0]    dx, dd;
  logic signed [LIN_W-1:0]   lx3, ld3;
  logic        [RAD_W-1:0]   rad3, rad4;
  logic signed [MUL_W-1:0]   mx4, md4;
  logic signed [CS_W-1:0]    tx_c, td_c;
  front_item_t               item5;

  // floor shift then clamp to the signed 32 bit range
  function automatic logic signed [CS_W-1:0] sat_cs(input logic signed [MUL_W-1:0] m);
    logic signed [SHR_W-1:0] s;
    s = SHR_W'(m >>> FRAC_BITS);
    if (s[SHR_W-1:CS_W-1] == '0 || s[SHR_W-1:CS_W-1] == '1) begin
      return s[CS_W-1:0];
    end else if (s[SHR_W-1]) begin
      return {1'b1, {(CS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CS_W-1){1'b1}}};
    end
  endfunction

  assign adv      = !queue_full;
  assign in_ready = adv;

  assign ax   = ox1[OFS_W-1] ? POS_W'(-ox1) : POS_W'(ox1);
  assign ay   = oy1[OFS_W-1] ? POS_W'(-oy1) : POS_W'(oy1);
  assign dx   = p_fyox - p_fxoy;
  assign dd   = p_pxoy - p_pyox;
  assign tx_c = sat_cs(mx4);
  assign td_c = sat_cs(md4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[FS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox1    <= $signed({1'b0, in_x}) - $signed({1'b0, cfg.cam_x});
      oy1    <= $signed({1'b0, in_y}) - $signed({1'b0, cfg.cam_y});

      ox2    <= ox1;
      oy2    <= oy1;
      p_fyox <= cfg.face_y * ox1;
      p_fxoy <= cfg.face_x * oy1;
      p_pxoy <= cfg.plane_x * oy1;
      p_pyox <= cfg.plane_y * ox1;
      sqx    <= ax * ax;
      sqy    <= ay * ay;

      ox3    <= ox2;
      oy3    <= oy2;
      lx3    <= LIN_W'(dx >>> FRAC_BITS);
      ld3    <= LIN_W'(dd >>> FRAC_BITS);
      rad3   <= RAD_W'(sqx) + RAD_W'(sqy);

      ox4    <= ox3;
      oy4    <= oy3;
      rad4   <= rad3;
      mx4    <= lx3 * cfg.inv_det;
      md4    <= ld3 * cfg.inv_det;

      item5.ox  <= ox4;
      item5.oy  <= oy4;
      item5.rad <= rad4;
      item5.tx  <= tx_c;
      item5.td  <= td_c;
      item5.vis <= !td_c[CS_W-1] && (td_c != '0);
    end
  end

  assign out_valid = vld[FS-1];
  assign out_item  = item5;

endmodule

FILE: design/ssp_queue.sv
// ----------------------------------------------------------------------------
// sprite projection queue
// short flop queue that decouples the front from the back
// ----------------------------------------------------------------------------
module ssp_queue import ssp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  front_item_t in_item,
  output logic        full,
  output logic        out_valid,
  output front_item_t out_item,
  input  logic        out_ready
);

  front_item_t     mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] cnt;
  logic            push, pop;

  assign full      = (cnt == Q_CW'(Q_DEPTH));
  assign out_valid = (cnt != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && !full;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= Q_CW'(Q_DEPTH))
    else $error("queue count above depth");
  a_cnt_push: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

FILE: design/ssp_back.sv
// ----------------------------------------------------------------------------
// sprite projection back
// square root, column and height dividers one bit per stage, screen clamps
// ----------------------------------------------------------------------------
module ssp_back import ssp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  front_item_t              in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OFS_W-1:0]  offset_x,
  output logic signed [OFS_W-1:0]  offset_y,
  output logic        [DIST_W-1:0] distance,
  output logic signed [CS_W-1:0]   camera_space_x,
  output logic signed [CS_W-1:0]   camera_space_depth,
  output logic                     visible,
  output logic signed [SCR_W-1:0]  screen_column,
  output logic        [SCR_W-1:0]  spr_height,
  output logic signed [SCR_W-1:0]  view_span
);

  localparam int NV      = DIV_STEPS + 3;
  localparam int EW      = SCR_W + 2;
  localparam int COL_MAX = (1 << (SCR_W - 1)) - 1;
  localparam int HGT_MAX = (1 << SCR_W) - 1;
  localparam int WID_MIN = -(1 << (SCR_W - 1));

  typedef struct packed {
    logic signed [OFS_W-1:0]    ox;
    logic signed [OFS_W-1:0]    oy;
    logic signed [CS_W-1:0]     tx;
    logic signed [CS_W-1:0]     td;
    logic                       vis;
    logic                       cneg;
    logic        [NUM_W-1:0]    cnum;
    logic        [DEN_W-1:0]    cden;
    logic        [DEN_W-1:0]    crem;
    logic        [NUM_W-1:0]    cq;
    logic        [NUM_W-1:0]    hnum;
    logic        [DEN_W-1:0]    hden;
    logic        [DEN_W-1:0]    hrem;
    logic        [NUM_W-1:0]    hq;
    logic        [RAD_PAD-1:0]  rad;
    logic        [SREM_W-1:0]   srem;
    logic        [SQ_STEPS-1:0] sq;
  } iter_t;

  typedef struct packed {
    logic signed [OFS_W-1:0]  ox;
    logic signed [OFS_W-1:0]  oy;
    logic        [DIST_W-1:0] dlen;
    logic signed [CS_W-1:0]   tx;
    logic signed [CS_W-1:0]   td;
    logic                     vis;
    logic signed [SCR_W-1:0]  col;
    logic        [SCR_W-1:0]  hgt;
  } clamp_t;

  typedef struct packed {
    clamp_t                  c;
    logic signed [SCR_W-1:0] wid;
  } result_t;

  logic                    adv;
  logic [NV-1:0]           vld;
  iter_t                   st [DIV_STEPS+1];
  iter_t                   prep_c;
  logic signed [SUM_W-1:0] csum;
  logic        [SUM_W-1:0] cmag;
  clamp_t                  clamp_c, clamp_q;
  result_t                 res_c, res_q;
  logic signed [EW-1:0]    half, start, fin, wid;

  assign adv      = !vld[NV-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  // set up numerators, divisors and radicand
  assign csum = SUM_W'(in_item.td) + SUM_W'(in_item.tx);
  assign cmag = csum[SUM_W-1] ? SUM_W'(-csum) : SUM_W'(csum);

  always_comb begin
    prep_c      = '0;
    prep_c.ox   = in_item.ox;
    prep_c.oy   = in_item.oy;
    prep_c.tx   = in_item.tx;
    prep_c.td   = in_item.td;
    prep_c.vis  = in_item.vis;
    prep_c.cneg = csum[SUM_W-1];
    prep_c.cnum = NUM_W'(cmag) * NUM_W'(VIEW_COLS);
    prep_c.cden = {in_item.td[CS_W-1:0], 1'b0};
    prep_c.hnum = HGT_NUM;
    prep_c.hden = DEN_W'(in_item.td[CS_W-1:0]);
    prep_c.rad  = RAD_PAD'(in_item.rad);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= prep_c;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_iter
    iter_t              nxt;
    logic [DEN_W:0]     ctrial, htrial;
    logic [SREM_W+1:0]  strial, sroot;

    always_comb begin
      nxt    = st[i];
      ctrial = {st[i].crem, st[i].cnum[NUM_W-1]};
      htrial = {st[i].hrem, st[i].hnum[NUM_W-1]};
      strial = {st[i].srem, st[i].rad[RAD_PAD-1 -: 2]};
      sroot  = (SREM_W+2)'({st[i].sq, 2'b01});
      nxt.cnum = st[i].cnum << 1;
      nxt.hnum = st[i].hnum << 1;
      if (ctrial >= {1'b0, st[i].cden}) begin
        nxt.crem = DEN_W'(ctrial - {1'b0, st[i].cden});
        nxt.cq   = {st[i].cq[NUM_W-2:0], 1'b1};
      end else begin
        nxt.crem = DEN_W'(ctrial);
        nxt.cq   = {st[i].cq[NUM_W-2:0], 1'b0};
      end
      if (htrial >= {1'b0, st[i].hden}) begin
        nxt.hrem = DEN_W'(htrial - {1'b0, st[i].hden});
        nxt.hq   = {st[i].hq[NUM_W-2:0], 1'b1};
      end else begin
        nxt.hrem = DEN_W'(htrial);
        nxt.hq   = {st[i].hq[NUM_W-2:0], 1'b0};
      end
      // square root digit, only in the first stages
      if (i < SQ_STEPS) begin
        nxt.rad = st[i].rad << 2;
        if (strial >= sroot) begin
          nxt.srem = SREM_W'(strial - sroot);
          nxt.sq   = {st[i].sq[SQ_STEPS-2:0], 1'b1};
        end else begin
          nxt.srem = SREM_W'(strial);
          nxt.sq   = {st[i].sq[SQ_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i+1] <= nxt;
      end
    end
  end

  // signed column and height saturation; both stay zero for a hidden sprite
  always_comb begin
    clamp_c.ox   = st[DIV_STEPS].ox;
    clamp_c.oy   = st[DIV_STEPS].oy;
    clamp_c.dlen = DIST_W'(st[DIV_STEPS].sq);
    clamp_c.tx   = st[DIV_STEPS].tx;
    clamp_c.td   = st[DIV_STEPS].td;
    clamp_c.vis  = st[DIV_STEPS].vis;
    clamp_c.col  = '0;
    clamp_c.hgt  = '0;
    if (st[DIV_STEPS].vis) begin
      if (st[DIV_STEPS].cneg) begin
        if (st[DIV_STEPS].cq > NUM_W'(COL_MAX + 1)) begin
          clamp_c.col = {1'b1, {(SCR_W-1){1'b0}}};
        end else begin
          clamp_c.col = SCR_W'(-st[DIV_STEPS].cq);
        end
      end else if (st[DIV_STEPS].cq > NUM_W'(COL_MAX)) begin
        clamp_c.col = SCR_W'(COL_MAX);
      end else begin
        clamp_c.col = st[DIV_STEPS].cq[SCR_W-1:0];
      end
      if (st[DIV_STEPS].hq > NUM_W'(HGT_MAX)) begin
        clamp_c.hgt = SCR_W'(HGT_MAX);
      end else begin
        clamp_c.hgt = st[DIV_STEPS].hq[SCR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clamp_q <= clamp_c;
    end
  end

  // visible span, start and end clamped to the screen
  always_comb begin
    half  = EW'({1'b0, clamp_q.hgt[SCR_W-1:1]});
    start = EW'(clamp_q.col) - half;
    if (start < 0) begin
      start = '0;
    end
    fin = EW'(clamp_q.col) + half;
    if (fin >= EW'(VIEW_COLS)) begin
      fin = EW'(VIEW_COLS - 1);
    end
    wid = fin - start;
    res_c.c = clamp_q;
    if (wid < EW'(WID_MIN)) begin
      res_c.wid = SCR_W'(WID_MIN);
    end else begin
      res_c.wid = wid[SCR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_c;
    end
  end

  assign out_valid          = vld[NV-1];
  assign offset_x           = res_q.c.ox;
  assign offset_y           = res_q.c.oy;
  assign distance           = res_q.c.dlen;
  assign camera_space_x     = res_q.c.tx;
  assign camera_space_depth = res_q.c.td;
  assign visible            = res_q.c.vis;
  assign screen_column      = res_q.c.col;
  assign spr_height         = res_q.c.hgt;
  assign view_span          = res_q.wid;

`ifndef SYNTHESIS
  a_vis_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> camera_space_depth > 0)
    else $error("visible result with depth not above zero");
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |->
      screen_column == '0 && spr_height == '0 && view_span == '0)
    else $error("hidden sprite with nonzero screen fields");
  a_wid_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> view_span <= SCR_W'(VIEW_COLS - 1))
    else $error("visible span beyond the screen");
`endif

endmodule

FILE: design/sprite_screen_projection.sv
// ----------------------------------------------------------------------------
// sprite screen projection
// camera-relative offset, distance, camera space and screen span of a sprite
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while no stall holds the flow; every front
// and back stage is pipelined; a full queue stalls only the 5 stage front, a
// stalled output stalls the back and, once the queue fills, the front as well
// reset: synchronous, clears all valid bits and the queue; camera registers
// return to origin, facing +x, plane y 43254, inverse determinant 1.0
// ----------------------------------------------------------------------------
module sprite_screen_projection import ssp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // sprite_pos_x, sprite_pos_y
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // offset_x, offset_y, distance, camera_space_x, camera_space_depth, visible,
  // screen_column, projected height, visible span
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cam_cfg_t                cfg;
  logic                    f_valid;
  front_item_t             f_item;
  logic                    q_full;
  logic                    q_valid;
  front_item_t             q_item;
  logic                    b_ready;
  logic signed [OFS_W-1:0] offset_x, offset_y;
  logic        [DIST_W-1:0] distance;
  logic signed [CS_W-1:0]  camera_space_x, camera_space_depth;
  logic                    visible;
  logic signed [SCR_W-1:0] screen_column, view_span;
  logic        [SCR_W-1:0] spr_height;

  // camera registers, low bits of the write data kept, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x   <= '0;
      cfg.cam_y   <= '0;
      cfg.face_x  <= FACE_X_RESET;
      cfg.face_y  <= '0;
      cfg.plane_x <= '0;
      cfg.plane_y <= PLANE_Y_RESET;
      cfg.inv_det <= INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_X:   cfg.cam_x   <= cfg_data[POS_W-1:0];
        REG_CAM_Y:   cfg.cam_y   <= cfg_data[POS_W-1:0];
        REG_FACE_X:  cfg.face_x  <= cfg_data[DIR_W-1:0];
        REG_FACE_Y:  cfg.face_y  <= cfg_data[DIR_W-1:0];
        REG_PLANE_X: cfg.plane_x <= cfg_data[DIR_W-1:0];
        REG_PLANE_Y: cfg.plane_y <= cfg_data[DIR_W-1:0];
        REG_INV_DET: cfg.inv_det <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // front: offsets, squares, camera transform, depth sign
  ssp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_x       (s_tdata[POS_W-1:0]),
    .in_y       (s_tdata[2*POS_W-1:POS_W]),
    .out_valid  (f_valid),
    .out_item   (f_item),
    .queue_full (q_full)
  );

  // decoupling queue
  ssp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .full      (q_full),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_ready (b_ready)
  );

  // back: distance root, column and height division, screen clamps
  ssp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (q_valid),
    .in_ready           (b_ready),
    .in_item            (q_item),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .offset_x           (offset_x),
    .offset_y           (offset_y),
    .distance           (distance),
    .camera_space_x     (camera_space_x),
    .camera_space_depth (camera_space_depth),
    .visible            (visible),
    .screen_column      (screen_column),
    .spr_height         (spr_height),
    .view_span          (view_span)
  );

  // result beat packing, first field in the low bits
  assign m_tdata = OUT_TDATA_W'({view_span, spr_height, screen_column, visible,
                                 camera_space_depth, camera_space_x, distance,
                                 offset_y, offset_x});

endmodule

FILE: verif/sprite_screen_projection_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite projection checker
// watches the sprite and result streams and the register port, predicts each
// result from its own copy of the camera registers and compares field by field
// ----------------------------------------------------------------------------
module sprite_screen_projection_checker import ssp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     result_count,
  output int                     visible_count
);

  typedef struct packed {
    logic signed [OFS_W-1:0]  ox;
    logic signed [OFS_W-1:0]  oy;
    logic        [DIST_W-1:0] dlen;
    logic signed [CS_W-1:0]   tx;
    logic signed [CS_W-1:0]   td;
    logic                     vis;
    logic signed [SCR_W-1:0]  col;
    logic        [SCR_W-1:0]  hgt;
    logic signed [SCR_W-1:0]  wid;
  } projection_t;

  cam_cfg_t    cam;
  projection_t projections_due[$];

  function automatic longint floor_div_pow(longint v);
    return v >>> FRAC_BITS;
  endfunction

  // floor(a*b / 2^F) clipped to 32 bit signed
  function automatic longint scale_sat(longint a, longint b);
    logic signed [127:0] p;
    p = (128'(signed'(a)) * 128'(signed'(b))) >>> FRAC_BITS;
    if (p > 128'sd2147483647) return 64'sd2147483647;
    if (p < -128'sd2147483648) return -64'sd2147483648;
    return longint'(p);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic projection_t project_sprite(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy);
    projection_t r;
    longint ox, oy, tx, td, col, hgt, half, st, en, wid;
    ox = longint'(sx) - longint'(cam.cam_x);
    oy = longint'(sy) - longint'(cam.cam_y);
    tx = scale_sat(floor_div_pow(longint'(cam.face_y) * ox - longint'(cam.face_x) * oy),
                   longint'(cam.inv_det));
    td = scale_sat(floor_div_pow(longint'(cam.plane_x) * oy - longint'(cam.plane_y) * ox),
                   longint'(cam.inv_det));
    col = 0; hgt = 0; wid = 0;
    if (td > 0) begin
      // c division truncates toward zero, as does sv on signed longint
      col = clip((longint'(VIEW_COLS) * (td + tx)) / (2 * td), -32768, 32767);
      hgt = clip((longint'(SCREEN_HEIGHT) <<< FRAC_BITS) / td, 0, 65535);
      half = hgt >>> 1;
      st = col - half;
      if (st < 0) st = 0;
      en = col + half;
      if (en >= VIEW_COLS) en = VIEW_COLS - 1;
      wid = clip(en - st, -32768, 32767);
    end
    r.ox   = OFS_W'(ox);
    r.oy   = OFS_W'(oy);
    r.dlen = DIST_W'(root_floor(longint'(ox * ox + oy * oy)));
    r.tx   = CS_W'(tx);
    r.td   = CS_W'(td);
    r.vis  = td > 0;
    r.col  = SCR_W'(col);
    r.hgt  = SCR_W'(hgt);
    r.wid  = SCR_W'(wid);
    return r;
  endfunction

  // result beat fields from the lowest bit up
  function automatic projection_t unpack_beat(logic [OUT_TDATA_W-1:0] d);
    projection_t r;
    int p;
    p = 0;
    r.ox   = d[p +: OFS_W];  p += OFS_W;
    r.oy   = d[p +: OFS_W];  p += OFS_W;
    r.dlen = d[p +: DIST_W]; p += DIST_W;
    r.tx   = d[p +: CS_W];   p += CS_W;
    r.td   = d[p +: CS_W];   p += CS_W;
    r.vis  = d[p];           p += 1;
    r.col  = d[p +: SCR_W];  p += SCR_W;
    r.hgt  = d[p +: SCR_W];  p += SCR_W;
    r.wid  = d[p +: SCR_W];
    return r;
  endfunction

  always @(posedge clk) begin
    projection_t got, want;
    if (rst) begin
      cam <= '{cam_x: '0, cam_y: '0, face_x: FACE_X_RESET, face_y: '0,
               plane_x: '0, plane_y: PLANE_Y_RESET, inv_det: INV_RESET};
      projections_due.delete();
      fail_count = 0; result_count = 0; visible_count = 0;
    end else begin
      if (s_tvalid && s_tready)
        projections_due.push_back(project_sprite(s_tdata[POS_W-1:0],
                                                 s_tdata[2*POS_W-1:POS_W]));
      if (m_tvalid && m_tready) begin
        got = unpack_beat(m_tdata);
        result_count++;
        if (got.vis) visible_count++;
        if (projections_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", m_tdata);
        end else begin
          want = projections_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch beat %0d", result_count);
              $display("  exp ox %0d oy %0d dlen %0d tx %0d td %0d vis %0d col %0d hgt %0d wid %0d",
                       want.ox, want.oy, want.dlen, want.tx, want.td, want.vis, want.col,
                       want.hgt, want.wid);
              $display("  got ox %0d oy %0d dlen %0d tx %0d td %0d vis %0d col %0d hgt %0d wid %0d",
                       got.ox, got.oy, got.dlen, got.tx, got.td, got.vis, got.col,
                       got.hgt, got.wid);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CAM_X:   cam.cam_x   <= cfg_data[POS_W-1:0];
          REG_CAM_Y:   cam.cam_y   <= cfg_data[POS_W-1:0];
          REG_FACE_X:  cam.face_x  <= cfg_data[DIR_W-1:0];
          REG_FACE_Y:  cam.face_y  <= cfg_data[DIR_W-1:0];
          REG_PLANE_X: cam.plane_x <= cfg_data[DIR_W-1:0];
          REG_PLANE_Y: cam.plane_y <= cfg_data[DIR_W-1:0];
          REG_INV_DET: cam.inv_det <= cfg_data[INV_W-1:0];
          default: ;
        endcase
      end
    end
    pending = projections_due.size();
  end

endmodule

FILE: verif/sprite_screen_projection_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite projection testbench
// drives sprite positions under several camera poses with random gaps and
// stalls; the checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module sprite_screen_projection_tb import ssp_pkg::*;;

  localparam int RAND_ITEMS = 1400;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_CAM_X;
  logic [CFG_W-1:0]       cfg_data = '0;

  int fail_count, pending, result_count, visible_count;
  int idle_cycles = 0;
  bit sending_done = 1'b0;
  bit long_hold = 1'b0;
  int poses = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_screen_projection u_dut (.*);

  sprite_screen_projection_checker u_chk (.*);

  // one sprite beat, preceded by a random gap; valid stays up when no gap follows
  task automatic send_sprite(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= IN_TDATA_W'({sy, sx});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // registers change only once the pipe has drained
  task automatic drain_pipe;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic load_pose(logic [POS_W-1:0] cx, logic [POS_W-1:0] cy, int fx, int fy,
                           int px, int py, int inv);
    drain_pipe();
    write_reg(REG_CAM_X, cx);
    write_reg(REG_CAM_Y, cy);
    write_reg(REG_FACE_X, CFG_W'(fx));
    write_reg(REG_FACE_Y, CFG_W'(fy));
    write_reg(REG_PLANE_X, CFG_W'(px));
    write_reg(REG_PLANE_Y, CFG_W'(py));
    write_reg(REG_INV_DET, CFG_W'(inv));
    poses++;
  endtask

  function automatic int rand_dir;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 131072 : -131072;
      1: return int'($urandom_range(0, 262144)) - 131072;
      2: return int'($urandom_range(0, 2 * 65536)) - 65536;
      default: return 0;
    endcase
  endfunction

  // near sprites keep the screen math in range; some go anywhere on the map
  function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] c);
    longint v;
    if ($urandom_range(0, 4) == 0) return POS_W'($urandom);
    v = longint'(c) + longint'($urandom_range(0, 20 * 65536)) - 10 * 65536;
    return POS_W'(v < 0 ? 0 : v);
  endfunction

  // result side: random stalls, one long hold early in the run
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (1000) @(negedge clk);
        long_hold = 1'b0;
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // watchdog over cycles with no beat on either side and no register write
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [POS_W-1:0] cx, cy;
    int fx, fy, px, py, inv;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pose: origin, facing +x
    send_sprite('0, '0);
    send_sprite(POS_W'(3 * 65536), POS_W'(0));
    send_sprite(POS_W'(5 * 65536), POS_W'(1 * 65536));
    send_sprite('1, '1);
    send_sprite('1, '0);
    send_sprite('0, '1);
    // camera mid-map: behind, in front, off edges, far, very close
    load_pose(POS_W'(2048 * 65536), POS_W'(2048 * 65536), 0, -65536, -43254, 0, -65536);
    send_sprite(POS_W'(2048 * 65536), POS_W'(2000 * 65536));
    send_sprite(POS_W'(2048 * 65536), POS_W'(2050 * 65536));
    send_sprite(POS_W'(2048 * 65536 + 1), POS_W'(2048 * 65536 - 1));
    send_sprite(POS_W'(2060 * 65536), POS_W'(2047 * 65536));
    send_sprite(POS_W'(2030 * 65536), POS_W'(2047 * 65536));
    send_sprite('0, '0);
    send_sprite('1, '1);
    // extremes of camera position and inverse determinant, large direction values
    load_pose('1, '1, 131072, -131072, -131072, 131072, 16777215);
    send_sprite('0, '0);
    send_sprite('1, POS_W'(0));
    send_sprite(POS_W'(0), '1);
    send_sprite('1, '1);
    load_pose('0, '0, -131072, 131072, 131072, -131072, -16777216);
    send_sprite('1, '1);
    send_sprite('1, '0);
    send_sprite('0, '1);
    send_sprite(POS_W'(65536), POS_W'(1));
    // index past the register list is ignored
    drain_pipe();
    write_reg(CFG_IDX_W'(7), '1);

    // random poses, each with a run of sprites; one long receiver hold
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        cx = $urandom_range(0, 3) == 0 ? POS_W'($urandom) : POS_W'($urandom_range(0, 4095) << 16);
        cy = $urandom_range(0, 3) == 0 ? POS_W'($urandom) : POS_W'($urandom_range(0, 4095) << 16);
        fx = rand_dir(); fy = rand_dir(); px = rand_dir(); py = rand_dir();
        case ($urandom_range(0, 3))
          0: inv = int'($urandom_range(0, 1 << 25)) - (1 << 24);
          1: inv = $urandom_range(0, 1) ? 16777215 : -16777216;
          default: inv = int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
        endcase
        load_pose(cx, cy, fx, fy, px, py, inv);
      end
      if (n == 300) long_hold = 1'b1;
      send_sprite(near(cx), near(cy));
    end

    drain_pipe();
    $display("covered %0d result beats over %0d camera poses, %0d sprites visible",
             result_count, poses + 1, visible_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ssp_pkg.sv
design/ssp_front.sv
design/ssp_queue.sv
design/ssp_back.sv
design/sprite_screen_projection.sv
verif/sprite_screen_projection_checker.sv
verif/sprite_screen_projection_tb.sv
